FILE: rtl/gdr_pkg.sv
// Shared types, field widths, register indexes and codes for the grid DDA raycaster.
// Depends on nothing; the front, back, top level and checker refer to it by scoped names.
`default_nettype none
package gdr_pkg;

	// Parameter defaults
	localparam int MAP_DIM_DEF    = 32;
	localparam int MAX_SCREEN_DEF = 1024;

	// Field widths
	localparam int COL_W   = 10;
	localparam int CELL_W  = 5;
	localparam int VAL_W   = 8;
	localparam int POS_W   = 15;
	localparam int VEC_W   = 16;
	localparam int SCR_W   = 11;
	localparam int DIST_W  = 16;
	localparam int FRAC_W  = 10;

	// Internal arithmetic widths
	localparam int DIV_W   = 32;
	localparam int CAM_W   = 28;
	localparam int RAY_W   = 29;
	localparam int ABS_W   = 28;
	localparam int LH_W    = 20;
	localparam int CAM_SH  = 17;
	localparam int DIST_SH = 12;
	localparam int LH_SH   = 8;
	localparam int MUL_SH  = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

	// Item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	// Queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic              action;
		logic [COL_W-1:0]  column;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [VAL_W-1:0]  cell_value;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] wall_distance;
		logic              hit_side;
		logic [CELL_W-1:0] hit_cell_x;
		logic [CELL_W-1:0] hit_cell_y;
		logic [SCR_W-1:0]  span_start;
		logic [SCR_W-1:0]  span_end;
		logic              left_map;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0]        player_x;
		logic [POS_W-1:0]        player_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
		logic [SCR_W-1:0]        screen_width;
		logic [SCR_W-1:0]        screen_height;
	} cfg_t;

	// Queue head as seen by the back part
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	// Back part control toward the front part
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/gdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module gdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/gdr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; shared by all divisions of the back part.
`default_nettype none
module gdr_div #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic      [W-1:0] quo
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [W:0]       shifted;
	logic [W+1:0]     diff;
	logic             fits;

	// Trial subtraction of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		fits    = !diff[W+1];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

FILE: rtl/gdr_front.sv
// Front part: accepts items on the command port and holds them in a short queue.
// Depends on gdr_pkg.
`default_nettype none
module gdr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire gdr_pkg::item_t     item,
	input  wire gdr_pkg::back_ctl_t ctl,
	output gdr_pkg::queue_head_t    head
);

	localparam int PTR_W = $clog2(gdr_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(gdr_pkg::QUEUE_DEPTH + 1);

	gdr_pkg::item_t   slot_q [gdr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             full;

	assign full = (cnt_q == CNT_W'(gdr_pkg::QUEUE_DEPTH));
	assign busy = full || ctl.clearing;
	assign push = start && !busy;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(gdr_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (ctl.pop) begin
				rptr_q <= (rptr_q == PTR_W'(gdr_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push && !ctl.pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (ctl.pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Store accepted transactions
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= item;
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = slot_q[rptr_q];

endmodule
`default_nettype wire

FILE: rtl/gdr_back.sv
// Back part: map clearing, cell writes, ray setup, DDA walk, distance and span.
// Depends on gdr_pkg, gdr_ram and gdr_div.
`default_nettype none
module gdr_back #(
	parameter int MAP_DIM    = gdr_pkg::MAP_DIM_DEF,
	parameter int MAX_SCREEN = gdr_pkg::MAX_SCREEN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gdr_pkg::queue_head_t head,
	input  wire gdr_pkg::cfg_t        cfg,
	output gdr_pkg::back_ctl_t        ctl,
	output logic                      done,
	output gdr_pkg::result_t          result
);

	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int MAXC  = (MAP_DIM > 32) ? MAP_DIM : 32;
	localparam int CW    = $clog2(MAXC + 1) + 1;
	localparam int NW    = $clog2(MAXC + 3) + gdr_pkg::FRAC_W + 1;
	localparam int PW    = NW + gdr_pkg::ABS_W;
	localparam int DW    = gdr_pkg::DIV_W;
	localparam int SW    = gdr_pkg::SCR_W;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_CAM     = 4'd2;
	localparam logic [3:0] S_MUL     = 4'd3;
	localparam logic [3:0] S_ABS     = 4'd4;
	localparam logic [3:0] S_INIT    = 4'd5;
	localparam logic [3:0] S_TEST    = 4'd6;
	localparam logic [3:0] S_ADDR    = 4'd7;
	localparam logic [3:0] S_DIST_GO = 4'd8;
	localparam logic [3:0] S_DIST    = 4'd9;
	localparam logic [3:0] S_LH_GO   = 4'd10;
	localparam logic [3:0] S_LH      = 4'd11;
	localparam logic [3:0] S_SPAN    = 4'd12;

	localparam logic [NW-1:0] ONE_CELL = NW'(1) << gdr_pkg::FRAC_W;
	localparam logic signed [gdr_pkg::CAM_W-1:0] CAM_OFS = gdr_pkg::CAM_W'(65536);
	localparam logic [gdr_pkg::DIST_W-1:0] DIST_SAT = '1;

	logic [3:0]                         state_q;
	logic [AW-1:0]                      clr_q;
	logic signed [gdr_pkg::CAM_W-1:0]   cam_q;
	logic signed [gdr_pkg::RAY_W-1:0]   rx_q;
	logic signed [gdr_pkg::RAY_W-1:0]   ry_q;
	logic [gdr_pkg::ABS_W-1:0]          ax_q;
	logic [gdr_pkg::ABS_W-1:0]          ay_q;
	logic                               negx_q;
	logic                               negy_q;
	logic [NW-1:0]                      nx_q;
	logic [NW-1:0]                      ny_q;
	logic [PW-1:0]                      px_q;
	logic [PW-1:0]                      py_q;
	logic signed [CW-1:0]               mx_q;
	logic signed [CW-1:0]               my_q;
	logic [NW-1:0]                      last_q;
	logic                               side_q;
	logic                               left_q;
	logic                               first_q;
	logic [gdr_pkg::DIST_W-1:0]         dist_q;
	logic [gdr_pkg::LH_W-1:0]           lh_q;
	gdr_pkg::result_t                   res_q;
	logic                               done_q;

	logic [SW-1:0]                      w_eff;
	logic [SW-1:0]                      h_eff;
	logic                               pop;
	logic                               div_go;
	logic [DW-1:0]                      div_num;
	logic [DW-1:0]                      div_den;
	logic                               div_done;
	logic [DW-1:0]                      div_quo;
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic [gdr_pkg::VAL_W-1:0]          ram_wdata;
	logic [AW-1:0]                      ram_raddr;
	logic [gdr_pkg::VAL_W-1:0]          ram_rdata;
	logic [gdr_pkg::ABS_W-1:0]          den_axis;
	logic                               write_ok;
	logic                               step_x;
	logic signed [CW-1:0]               nmx;
	logic signed [CW-1:0]               nmy;
	logic                               outside;
	logic signed [gdr_pkg::RAY_W+gdr_pkg::VEC_W-1:0] prod_x;
	logic signed [gdr_pkg::RAY_W+gdr_pkg::VEC_W-1:0] prod_y;
	logic [gdr_pkg::LH_W-1:0]           half_h;
	logic [gdr_pkg::LH_W-1:0]           half_lh;
	logic [gdr_pkg::LH_W:0]             end_sum;

	// Clamp screen size
	always_comb begin
		w_eff = cfg.screen_width;
		if (w_eff == '0) begin
			w_eff = SW'(1);
		end else if (32'(cfg.screen_width) > MAX_SCREEN) begin
			w_eff = SW'(MAX_SCREEN);
		end
		h_eff = cfg.screen_height;
		if (32'(cfg.screen_height) > MAX_SCREEN) begin
			h_eff = SW'(MAX_SCREEN);
		end
	end

	assign pop          = (state_q == S_IDLE) && head.valid;
	assign ctl.pop      = pop;
	assign ctl.clearing = (state_q == S_CLEAR);
	assign den_axis     = side_q ? ay_q : ax_q;
	assign write_ok     = (32'(head.item.cell_x) < MAP_DIM) && (32'(head.item.cell_y) < MAP_DIM);

	// Map writes: clearing sweep or cell write transaction
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (pop && (head.item.action == gdr_pkg::ACT_WRITE) && write_ok) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(head.item.cell_y) * AW'(MAP_DIM) + AW'(head.item.cell_x);
			ram_wdata = head.item.cell_value;
		end
	end

	assign ram_raddr = AW'($unsigned(my_q)) * AW'(MAP_DIM) + AW'($unsigned(mx_q));

	gdr_ram #(
		.WIDTH (gdr_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Divider operands
	always_comb begin
		div_go  = 1'b0;
		div_num = '0;
		div_den = '0;
		unique case (state_q)
			S_IDLE: begin
				div_go  = pop && (head.item.action == gdr_pkg::ACT_CAST);
				div_num = DW'(head.item.column) << gdr_pkg::CAM_SH;
				div_den = DW'(w_eff);
			end
			S_DIST_GO: begin
				div_go  = (den_axis != '0);
				div_num = DW'(last_q) << gdr_pkg::DIST_SH;
				div_den = DW'(den_axis);
			end
			S_LH_GO: begin
				div_go  = (dist_q != '0);
				div_num = DW'(h_eff) << gdr_pkg::LH_SH;
				div_den = DW'(dist_q);
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	gdr_div #(
		.W (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Ray components from the camera offset
	assign prod_x = cfg.plane_x * cam_q;
	assign prod_y = cfg.plane_y * cam_q;

	// One DDA step: advance along the nearer boundary, ties go to y
	always_comb begin
		step_x  = (px_q < py_q);
		nmx     = mx_q;
		nmy     = my_q;
		if (step_x) begin
			nmx = negx_q ? mx_q - CW'(1) : mx_q + CW'(1);
		end else begin
			nmy = negy_q ? my_q - CW'(1) : my_q + CW'(1);
		end
		outside = (nmx < 0) || (nmx >= $signed(CW'(MAP_DIM))) ||
			(nmy < 0) || (nmy >= $signed(CW'(MAP_DIM)));
	end

	// Wall span from line height
	always_comb begin
		half_h  = gdr_pkg::LH_W'(h_eff >> 1);
		half_lh = lh_q >> 1;
		end_sum = {1'b0, half_lh} + {1'b0, half_h};
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop && (head.item.action == gdr_pkg::ACT_CAST)) begin
						state_q <= S_CAM;
					end
				end
				S_CAM: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_ABS;
				S_ABS:  state_q <= S_INIT;
				S_INIT: state_q <= S_TEST;
				S_TEST: begin
					if ((!first_q && ram_rdata != '0) || outside) begin
						state_q <= S_DIST_GO;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= S_TEST;
				S_DIST_GO: begin
					state_q <= (den_axis != '0) ? S_DIST : S_LH_GO;
				end
				S_DIST: begin
					if (div_done) begin
						state_q <= S_LH_GO;
					end
				end
				S_LH_GO: begin
					state_q <= (dist_q != '0) ? S_LH : S_SPAN;
				end
				S_LH: begin
					if (div_done) begin
						state_q <= S_SPAN;
					end
				end
				S_SPAN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_CAM: begin
				if (div_done) begin
					cam_q <= $signed(gdr_pkg::CAM_W'(div_quo)) - CAM_OFS;
				end
			end
			S_MUL: begin
				rx_q <= gdr_pkg::RAY_W'(cfg.dir_x) + gdr_pkg::RAY_W'(prod_x >>> gdr_pkg::MUL_SH);
				ry_q <= gdr_pkg::RAY_W'(cfg.dir_y) + gdr_pkg::RAY_W'(prod_y >>> gdr_pkg::MUL_SH);
			end
			S_ABS: begin
				negx_q  <= rx_q < 0;
				negy_q  <= ry_q < 0;
				ax_q    <= gdr_pkg::ABS_W'((rx_q < 0) ? -rx_q : rx_q);
				ay_q    <= gdr_pkg::ABS_W'((ry_q < 0) ? -ry_q : ry_q);
				nx_q    <= (rx_q < 0) ? NW'(cfg.player_x[gdr_pkg::FRAC_W-1:0]) :
					ONE_CELL - NW'(cfg.player_x[gdr_pkg::FRAC_W-1:0]);
				ny_q    <= (ry_q < 0) ? NW'(cfg.player_y[gdr_pkg::FRAC_W-1:0]) :
					ONE_CELL - NW'(cfg.player_y[gdr_pkg::FRAC_W-1:0]);
				mx_q    <= $signed(CW'(cfg.player_x >> gdr_pkg::FRAC_W));
				my_q    <= $signed(CW'(cfg.player_y >> gdr_pkg::FRAC_W));
				first_q <= 1'b1;
				left_q  <= 1'b0;
				side_q  <= 1'b0;
				last_q  <= '0;
			end
			S_INIT: begin
				px_q <= PW'(nx_q) * PW'(ay_q);
				py_q <= PW'(ny_q) * PW'(ax_q);
			end
			S_TEST: begin
				if (first_q || ram_rdata == '0) begin
					first_q <= 1'b0;
					mx_q    <= nmx;
					my_q    <= nmy;
					left_q  <= outside;
					if (step_x) begin
						last_q <= nx_q;
						nx_q   <= nx_q + ONE_CELL;
						px_q   <= px_q + (PW'(ay_q) << gdr_pkg::FRAC_W);
						side_q <= 1'b0;
					end else begin
						last_q <= ny_q;
						ny_q   <= ny_q + ONE_CELL;
						py_q   <= py_q + (PW'(ax_q) << gdr_pkg::FRAC_W);
						side_q <= 1'b1;
					end
				end
			end
			S_DIST_GO: begin
				dist_q <= DIST_SAT;
			end
			S_DIST: begin
				if (div_done) begin
					dist_q <= (div_quo > DW'(DIST_SAT)) ? DIST_SAT : div_quo[gdr_pkg::DIST_W-1:0];
				end
			end
			S_LH_GO: begin
				lh_q <= gdr_pkg::LH_W'(2 * MAX_SCREEN);
			end
			S_LH: begin
				if (div_done) begin
					lh_q <= gdr_pkg::LH_W'(div_quo);
				end
			end
			S_SPAN: begin
				res_q.wall_distance <= dist_q;
				res_q.hit_side      <= side_q;
				res_q.hit_cell_x    <= left_q ? '0 : gdr_pkg::CELL_W'($unsigned(mx_q));
				res_q.hit_cell_y    <= left_q ? '0 : gdr_pkg::CELL_W'($unsigned(my_q));
				res_q.left_map      <= left_q;
				res_q.span_start    <= (half_h > half_lh) ? SW'(half_h - half_lh) : '0;
				res_q.span_end      <= (end_sum > (gdr_pkg::LH_W + 1)'(h_eff)) ? h_eff : SW'(end_sum);
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

FILE: rtl/grid_dda_column_raycaster.sv
// A write transaction is written to the map at the clock edge that pops it from the queue.
// A cast walks the DDA step by step with a map read per step, and uses up to three divisions
// in the shared divider; the back part takes no new item until the cast is done, and queued
// items wait behind it. The result strobe lasts one cycle.
// Reset: a clearing sweep writes zero to all MAP_DIM*MAP_DIM map cells; busy stays high.
// Top level: configuration registers, front queue and back sequencer.
// Depends on gdr_pkg, gdr_front and gdr_back.
`default_nettype none
module grid_dda_column_raycaster #(
	parameter int MAP_DIM    = gdr_pkg::MAP_DIM_DEF,
	parameter int MAX_SCREEN = gdr_pkg::MAX_SCREEN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire gdr_pkg::item_t                   item,
	input  wire logic                             cfg_we,
	input  wire logic [gdr_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [gdr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                                  done,
	output gdr_pkg::result_t                      result
);

	gdr_pkg::cfg_t        cfg_q;
	gdr_pkg::queue_head_t head;
	gdr_pkg::back_ctl_t   ctl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.player_x      <= 15'd16384;
			cfg_q.player_y      <= 15'd16384;
			cfg_q.dir_x         <= -16'sd16384;
			cfg_q.dir_y         <= 16'sd0;
			cfg_q.plane_x       <= 16'sd0;
			cfg_q.plane_y       <= 16'sd10813;
			cfg_q.screen_width  <= 11'd320;
			cfg_q.screen_height <= 11'd240;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				gdr_pkg::REG_PLAYER_X:      cfg_q.player_x      <= cfg_wdata[gdr_pkg::POS_W-1:0];
				gdr_pkg::REG_PLAYER_Y:      cfg_q.player_y      <= cfg_wdata[gdr_pkg::POS_W-1:0];
				gdr_pkg::REG_DIR_X:         cfg_q.dir_x         <= $signed(cfg_wdata);
				gdr_pkg::REG_DIR_Y:         cfg_q.dir_y         <= $signed(cfg_wdata);
				gdr_pkg::REG_PLANE_X:       cfg_q.plane_x       <= $signed(cfg_wdata);
				gdr_pkg::REG_PLANE_Y:       cfg_q.plane_y       <= $signed(cfg_wdata);
				gdr_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata[gdr_pkg::SCR_W-1:0];
				gdr_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[gdr_pkg::SCR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gdr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.ctl    (ctl),
		.head   (head)
	);

	gdr_back #(
		.MAP_DIM    (MAP_DIM),
		.MAX_SCREEN (MAX_SCREEN)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire

FILE: rtl/gdr_checker.sv
// Port-level checker for the raycaster, bound to the top level.
// Depends on gdr_pkg and grid_dda_column_raycaster.
`default_nettype none
module gdr_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire gdr_pkg::item_t                 item,
	input wire logic                           cfg_we,
	input wire logic [gdr_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input wire logic [gdr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input wire logic                           done,
	input wire gdr_pkg::result_t               result
);

	// Strobes never touch: the sequencer leaves S_SPAN for S_IDLE after each one
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobes back to back");

	// A ray that leaves the map reports no cell
	a_left_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.left_map) |-> (result.hit_cell_x == '0 && result.hit_cell_y == '0))
		else $error("left_map with nonzero cell");

	// The span is never inverted
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.span_start <= result.span_end))
		else $error("span start after span end");

	// Busy right after reset while the map clears
	a_reset_busy: assert property (@(posedge clk)
		$rose(arst_n) |-> busy) else $error("not busy during map clear");

endmodule

bind grid_dda_column_raycaster gdr_checker u_gdr_checker (.*);
`default_nettype wire
